/* hw/rtl/nf_pkg.sv */
// Notification fragmenter package: the job word passed from front to back,
// header constants and beat positions. No dependencies.
`timescale 1ns / 1ps

package nf_pkg;

    // Smallest link MTU that the block will use.
    localparam logic [15:0] MIN_MTU = 16'd23;
    // Bytes the link layer keeps out of every packet.
    localparam logic [15:0] ATT_OVERHEAD = 16'd3;

    // Framed header: two magic bytes, then id, offset, total (little endian).
    localparam logic [7:0] HDR_MAGIC0 = 8'hF3;
    localparam logic [7:0] HDR_MAGIC1 = 8'h2C;
    localparam int unsigned HDR_LEN = 8;

    // Beat positions inside one framed job; the payload byte follows the header.
    localparam logic [3:0] BEAT_MAGIC0   = 4'd0;
    localparam logic [3:0] BEAT_MAGIC1   = 4'd1;
    localparam logic [3:0] BEAT_ID_LO    = 4'd2;
    localparam logic [3:0] BEAT_ID_HI    = 4'd3;
    localparam logic [3:0] BEAT_OFF_LO   = 4'd4;
    localparam logic [3:0] BEAT_OFF_HI   = 4'd5;
    localparam logic [3:0] BEAT_TOTAL_LO = 4'd6;
    localparam logic [3:0] BEAT_TOTAL_HI = 4'd7;
    localparam logic [3:0] BEAT_PAYLOAD  = 4'd8;

    // One classified input byte waiting to be written out.
    typedef struct packed {
        logic        err;     // message too long, emit the error word only
        logic        hdr;     // first byte of a framed chunk, emit header first
        logic [7:0]  data;    // payload byte
        logic        pend;    // payload byte closes its packet
        logic [15:0] id;      // header message id
        logic [15:0] offset;  // header chunk offset
        logic [15:0] total;   // header message total
    } t_job;

endpackage

/* hw/rtl/notification_fragmenter_top.sv */
// Top level of the notification fragmenter: front end, job queue, back end.
// Uses nf_pkg, nf_front, nf_queue and nf_back.
`timescale 1ns / 1ps

// Usage
//   Input channel: one word per message byte (i_action, i_msg_start,
//   i_data_byte, i_msg_length), taken when i_in_valid is high and
//   o_in_stall is low. o_in_stall is high only while the job queue is full.
//   Output channel: one word per packet byte, taken when o_out_valid is high
//   and i_out_stall is low; o_last closes the words caused by one input word.
//   Configuration: i_cfg_data is written to the link MTU register whenever
//   i_cfg_valid is high; o_cfg_ready is always high. Write only while idle.
// Timing
//   The front classifies an input word in the cycle it is taken; its job is
//   registered in the queue, then its first word in the back end's output register.
//   A raw or mid-chunk byte gives one output word, a chunk-opening byte
//   nine (eight header bytes + payload), so throughput is set by the back
//   end's single output register. Input words that produce nothing push no
//   job; they too wait while the queue is full.
// Reset
//   Synchronous, active low: idle, message id zero, MTU 23, queue empty.
//   When the receiver stalls, the output word holds, the queue fills, and
//   then o_in_stall rises.
module notification_fragmenter_top
    import nf_pkg::*;
#(
    parameter int unsigned MAX_MTU     = 517,
    parameter int unsigned MAX_MESSAGE = 8192,
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic        i_msg_start,
    input  logic [7:0]  i_data_byte,
    input  logic [15:0] i_msg_length,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_packet_end,
    output logic        o_too_long,
    output logic        o_last
);

    logic push;
    logic q_full;
    logic pop;
    logic head_valid;
    t_job job;
    t_job head;

    assign o_cfg_ready = 1'b1;

    // Front end: classify and track message state.
    nf_front #(
        .MAX_MTU     (MAX_MTU),
        .MAX_MESSAGE (MAX_MESSAGE)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_msg_start  (i_msg_start),
        .i_data_byte  (i_data_byte),
        .i_msg_length (i_msg_length),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_job        (job)
    );

    // Job queue between the two halves.
    nf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (job),
        .o_full       (q_full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    // Back end: expand jobs into output words.
    nf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_packet_end (o_packet_end),
        .o_too_long   (o_too_long),
        .o_last       (o_last)
    );

endmodule

/* hw/rtl/nf_front.sv */
// Front end of the notification fragmenter: accepts input words, tracks the
// message state and pushes one job per result-producing word. Uses nf_pkg.
`timescale 1ns / 1ps

module nf_front
    import nf_pkg::*;
#(
    parameter int unsigned MAX_MTU     = 517,
    parameter int unsigned MAX_MESSAGE = 8192
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic        i_msg_start,
    input  logic [7:0]  i_data_byte,
    input  logic [15:0] i_msg_length,
    input  logic        i_q_full,
    output logic        o_push,
    output t_job        o_job
);

    localparam int unsigned LEN_W = $clog2(MAX_MESSAGE + 1);
    localparam int unsigned CAP_W = $clog2(MAX_MTU - 2);

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_RAW    = 2'd1;
    localparam logic [1:0] MODE_FRAMED = 2'd2;
    localparam logic [1:0] MODE_DROP   = 2'd3;

    logic [15:0]      r_mtu;
    logic [1:0]       r_mode,  n_mode;
    logic [15:0]      r_id,    n_id;
    logic [LEN_W-1:0] r_off,   n_off;
    logic [LEN_W-1:0] r_total, n_total;
    logic [CAP_W-1:0] r_fill,  n_fill;
    logic [CAP_W-1:0] r_cap,   n_cap;

    logic accept;

    // The queue full flag is the only thing that holds off the sender.
    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    // Classify the word and compute the next message state.
    always_comb begin
        logic [15:0]      mtu_c;
        logic [CAP_W-1:0] cap_full;
        logic [LEN_W-1:0] off_inc;
        logic [CAP_W-1:0] fill_inc;
        logic             go;
        logic             done;

        n_mode  = r_mode;
        n_id    = r_id;
        n_off   = r_off;
        n_total = r_total;
        n_fill  = r_fill;
        n_cap   = r_cap;
        o_push  = 1'b0;
        o_job   = '0;
        go      = 1'b0;

        mtu_c = r_mtu;
        if (mtu_c < MIN_MTU) begin
            mtu_c = MIN_MTU;
        end
        if (mtu_c > 16'(MAX_MTU)) begin
            mtu_c = 16'(MAX_MTU);
        end
        cap_full = CAP_W'(mtu_c - ATT_OVERHEAD);
        off_inc  = '0;
        fill_inc = '0;
        done     = 1'b0;

        if (accept) begin
            if (i_action) begin
                n_mode = MODE_IDLE;
            end else begin
                go = 1'b1;
                if (i_msg_start) begin
                    if (i_msg_length == 16'd0) begin
                        n_mode = MODE_IDLE;
                        go     = 1'b0;
                    end else if (i_msg_length > 16'(MAX_MESSAGE)) begin
                        n_mode    = MODE_DROP;
                        go        = 1'b0;
                        o_push    = 1'b1;
                        o_job.err = 1'b1;
                    end else begin
                        n_total = LEN_W'(i_msg_length);
                        n_off   = '0;
                        n_fill  = '0;
                        if (i_msg_length <= 16'(cap_full)) begin
                            n_mode = MODE_RAW;
                            n_cap  = cap_full;
                        end else begin
                            n_mode = MODE_FRAMED;
                            n_cap  = cap_full - CAP_W'(HDR_LEN);
                            n_id   = r_id + 16'd1;
                        end
                    end
                end

                if (go && n_mode == MODE_RAW) begin
                    // Raw message: the byte goes out as it is.
                    off_inc    = n_off + LEN_W'(1);
                    done       = (off_inc >= n_total);
                    o_push     = 1'b1;
                    o_job.data = i_data_byte;
                    o_job.pend = done;
                    n_off      = off_inc;
                    if (done) begin
                        n_mode = MODE_IDLE;
                    end
                end else if (go && n_mode == MODE_FRAMED) begin
                    // Framed message: a new chunk opens with the header.
                    off_inc      = n_off + LEN_W'(1);
                    fill_inc     = n_fill + CAP_W'(1);
                    done         = (fill_inc >= n_cap) || (off_inc >= n_total);
                    o_push       = 1'b1;
                    o_job.hdr    = (n_fill == '0);
                    o_job.data   = i_data_byte;
                    o_job.pend   = done;
                    o_job.id     = n_id;
                    o_job.offset = 16'(n_off);
                    o_job.total  = 16'(n_total);
                    n_off        = off_inc;
                    n_fill       = done ? '0 : fill_inc;
                    if (off_inc >= n_total) begin
                        n_mode = MODE_IDLE;
                    end
                end
            end
        end
    end

    // Message state and the MTU register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mtu   <= MIN_MTU;
            r_mode  <= MODE_IDLE;
            r_id    <= '0;
            r_off   <= '0;
            r_total <= '0;
            r_fill  <= '0;
            r_cap   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_mtu <= i_cfg_data;
            end
            r_mode  <= n_mode;
            r_id    <= n_id;
            r_off   <= n_off;
            r_total <= n_total;
            r_fill  <= n_fill;
            r_cap   <= n_cap;
        end
    end

    // An open raw message still has bytes to come.
    a_raw_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_RAW) |-> (r_off < r_total))
        else $error("raw message open past its total");

    // An open framed message never holds a full chunk.
    a_chunk_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_FRAMED) |-> (r_fill < r_cap && r_off < r_total))
        else $error("framed message holds a full chunk or is complete");

    // A chunk header never names an offset at or beyond the total.
    a_hdr_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_job.hdr) |-> (o_job.offset < o_job.total))
        else $error("header offset out of range");

endmodule

/* hw/rtl/nf_queue.sv */
// Short job queue between the front and back of the fragmenter.
// Register based ring with a fill count. Uses nf_pkg for the job type.
`timescale 1ns / 1ps

module nf_queue
    import nf_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_head_valid,
    output t_job o_head
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd];

    // Job storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

/* hw/rtl/nf_back.sv */
// Back end of the fragmenter: expands each queued job into output words
// (error word, raw byte, or header plus byte) through an output register.
// Uses nf_pkg.
`timescale 1ns / 1ps

module nf_back
    import nf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_head_valid,
    input  t_job       i_head,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_packet_end,
    output logic       o_too_long,
    output logic       o_last
);

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_pend;
    logic       r_out_err;
    logic       r_out_last;
    logic [3:0] r_beat, n_beat;

    logic       advance;
    logic       emit;
    logic [7:0] w_byte;
    logic       w_pend;
    logic       w_last;

    assign advance = !r_out_valid || !i_out_stall;
    assign emit    = advance && i_head_valid;

    // Word for the current beat of the head job.
    always_comb begin
        w_byte = i_head.data;
        w_pend = i_head.pend;
        w_last = 1'b1;
        if (i_head.err) begin
            w_byte = 8'd0;
            w_pend = 1'b0;
        end else if (i_head.hdr && r_beat != BEAT_PAYLOAD) begin
            w_pend = 1'b0;
            w_last = 1'b0;
            unique case (r_beat)
                BEAT_MAGIC0:   w_byte = HDR_MAGIC0;
                BEAT_MAGIC1:   w_byte = HDR_MAGIC1;
                BEAT_ID_LO:    w_byte = i_head.id[7:0];
                BEAT_ID_HI:    w_byte = i_head.id[15:8];
                BEAT_OFF_LO:   w_byte = i_head.offset[7:0];
                BEAT_OFF_HI:   w_byte = i_head.offset[15:8];
                BEAT_TOTAL_LO: w_byte = i_head.total[7:0];
                BEAT_TOTAL_HI: w_byte = i_head.total[15:8];
                default:       w_byte = i_head.data;
            endcase
        end
    end

    // The job leaves the queue with its final word.
    assign o_pop  = emit && w_last;
    assign n_beat = o_pop ? BEAT_MAGIC0 : r_beat + 4'd1;

    // Beat counter and output register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_beat      <= BEAT_MAGIC0;
        end else if (advance) begin
            r_out_valid <= i_head_valid;
            if (emit) begin
                r_beat <= n_beat;
            end
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= w_byte;
            r_out_pend <= w_pend;
            r_out_err  <= i_head.err;
            r_out_last <= w_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_packet_end = r_out_pend;
    assign o_too_long   = r_out_err;
    assign o_last       = r_out_last;

    // A header in progress keeps its job at the head of the queue.
    a_beat_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_beat != BEAT_MAGIC0) |-> (i_head_valid && i_head.hdr && !i_head.err))
        else $error("header beat without a framed job at the head");

    // An error job is always a single word.
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && i_head.err) |=> (r_beat == BEAT_MAGIC0 && r_out_last))
        else $error("error job took more than one word");

    // No word is offered right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid)
        else $error("output valid after reset");

endmodule

/* sim/notification_fragmenter_checker.sv */
// Scoreboard for the notification fragmenter: follows the link MTU register,
// predicts every packet word from the accepted input words and compares them.
// Depends on nf_pkg for the header bytes and the MTU limits.
`timescale 1ns / 1ps

module notification_fragmenter_checker
    import nf_pkg::*;
#(
    parameter int unsigned MAX_MTU     = 517,
    parameter int unsigned MAX_MESSAGE = 8192
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_action,
    input  logic        i_msg_start,
    input  logic [7:0]  i_data_byte,
    input  logic [15:0] i_msg_length,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_out_byte,
    input  logic        i_packet_end,
    input  logic        i_too_long,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_RAW,
        MODE_FRAMED,
        MODE_DROP
    } t_frag_mode;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       packet_end;
        logic       too_long;
        logic       last;
    } t_packet_word;

    t_packet_word due_words[$];
    logic [15:0]  mtu_reg;
    logic [15:0]  msg_id;
    logic [15:0]  sent_count;
    logic [15:0]  fill_count;
    logic [15:0]  msg_total;
    logic [15:0]  chunk_room;
    t_frag_mode   frag_mode;
    int           fails;

    function automatic void queue_word(input logic [7:0] data, input logic pend,
                                       input logic err, input logic fin);
        due_words.push_back('{data, pend, err, fin});
    endfunction

    // Works out the packet words that one accepted input word causes.
    function automatic void fragment_word(input logic act, input logic start,
                                          input logic [7:0] data, input logic [15:0] len);
        logic [15:0] mtu_use;
        logic [15:0] room;
        logic        closes;
        if (act) begin
            frag_mode = MODE_IDLE;
            return;
        end
        if (start) begin
            if (len == 16'd0) begin
                frag_mode = MODE_IDLE;
                return;
            end
            if (len > MAX_MESSAGE) begin
                frag_mode = MODE_DROP;
                queue_word(8'h00, 1'b0, 1'b1, 1'b1);
                return;
            end
            mtu_use = mtu_reg;
            if (mtu_use < MIN_MTU) begin
                mtu_use = MIN_MTU;
            end
            if (mtu_use > MAX_MTU) begin
                mtu_use = 16'(MAX_MTU);
            end
            room       = mtu_use - ATT_OVERHEAD;
            msg_total  = len;
            sent_count = '0;
            fill_count = '0;
            if (len <= room) begin
                frag_mode  = MODE_RAW;
                chunk_room = room;
            end else begin
                frag_mode  = MODE_FRAMED;
                chunk_room = room - 16'(HDR_LEN);
                msg_id     = msg_id + 16'd1;
            end
        end
        case (frag_mode)
            MODE_RAW: begin
                sent_count = sent_count + 16'd1;
                closes = (sent_count >= msg_total);
                queue_word(data, closes, 1'b0, 1'b1);
                if (closes) begin
                    frag_mode = MODE_IDLE;
                end
            end
            MODE_FRAMED: begin
                // A chunk opens with its header; the offset is the one before this byte.
                if (fill_count == 16'd0) begin
                    queue_word(HDR_MAGIC0, 1'b0, 1'b0, 1'b0);
                    queue_word(HDR_MAGIC1, 1'b0, 1'b0, 1'b0);
                    queue_word(msg_id[7:0], 1'b0, 1'b0, 1'b0);
                    queue_word(msg_id[15:8], 1'b0, 1'b0, 1'b0);
                    queue_word(sent_count[7:0], 1'b0, 1'b0, 1'b0);
                    queue_word(sent_count[15:8], 1'b0, 1'b0, 1'b0);
                    queue_word(msg_total[7:0], 1'b0, 1'b0, 1'b0);
                    queue_word(msg_total[15:8], 1'b0, 1'b0, 1'b0);
                end
                fill_count = fill_count + 16'd1;
                sent_count = sent_count + 16'd1;
                closes = (fill_count >= chunk_room) || (sent_count >= msg_total);
                queue_word(data, closes, 1'b0, 1'b1);
                if (closes) begin
                    fill_count = '0;
                    if (sent_count >= msg_total) begin
                        frag_mode = MODE_IDLE;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fails++;
        end
    endfunction

    function automatic void check_word(input t_packet_word seen);
        t_packet_word want;
        if (due_words.size() == 0) begin
            $error("unexpected word: out_byte %0h packet_end %0b too_long %0b last %0b",
                   seen.out_byte, seen.packet_end, seen.too_long, seen.last);
            fails++;
            return;
        end
        want = due_words.pop_front();
        compare_field("out_byte", want.out_byte, seen.out_byte);
        compare_field("packet_end", {7'd0, want.packet_end}, {7'd0, seen.packet_end});
        compare_field("too_long", {7'd0, want.too_long}, {7'd0, seen.too_long});
        compare_field("last", {7'd0, want.last}, {7'd0, seen.last});
    endfunction

    // All handshakes are sampled at the rising edge; inputs are settled by then.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mtu_reg    = MIN_MTU;
            msg_id     = '0;
            sent_count = '0;
            fill_count = '0;
            msg_total  = '0;
            chunk_room = '0;
            frag_mode  = MODE_IDLE;
            due_words.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                mtu_reg = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                fragment_word(i_action, i_msg_start, i_data_byte, i_msg_length);
            end
            if (i_out_valid && !i_out_stall) begin
                check_word('{i_out_byte, i_packet_end, i_too_long, i_last});
            end
        end
        o_pending    <= due_words.size();
        o_fail_count <= fails;
    end

endmodule

/* sim/tb_notification_fragmenter_top.sv */
// Testbench top for the notification fragmenter: clock, reset, stimulus,
// receiver stalls, watchdog and verdict. Uses nf_pkg, the block's top level
// and notification_fragmenter_checker.
`timescale 1ns / 1ps

module tb_notification_fragmenter_top;
    import nf_pkg::*;

    localparam int unsigned MAX_MTU        = 517;
    localparam int unsigned MAX_MESSAGE    = 8192;
    localparam int          MTU_STEPS      = 7;
    localparam int          WORDS_PER_STEP = 30;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          SETTLE_CYCLES  = 16;
    localparam int          WATCHDOG_LIMIT = 4000;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data   = '0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic        action     = 1'b0;
    logic        msg_start  = 1'b0;
    logic [7:0]  data_byte  = '0;
    logic [15:0] msg_length = '0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [7:0]  out_byte;
    logic        packet_end;
    logic        too_long;
    logic        last;

    int          fail_count;
    int          pending;
    int          tx_idle_pct  = 0;
    int          rx_idle_pct  = 0;
    logic [15:0] mtu_setting  = 16'd23;
    int          useful_words = 0;
    int          hold_seq     = 0;
    int          hold_seen    = 0;
    int          hold_left    = 0;
    int          quiet_cycles = 0;

    // 50 MHz clock.
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    notification_fragmenter_top #(
        .MAX_MTU     (MAX_MTU),
        .MAX_MESSAGE (MAX_MESSAGE)
    ) u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_action     (action),
        .i_msg_start  (msg_start),
        .i_data_byte  (data_byte),
        .i_msg_length (msg_length),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_out_byte   (out_byte),
        .o_packet_end (packet_end),
        .o_too_long   (too_long),
        .o_last       (last)
    );

    notification_fragmenter_checker #(
        .MAX_MTU     (MAX_MTU),
        .MAX_MESSAGE (MAX_MESSAGE)
    ) u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_action     (action),
        .i_msg_start  (msg_start),
        .i_data_byte  (data_byte),
        .i_msg_length (msg_length),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_byte   (out_byte),
        .i_packet_end (packet_end),
        .i_too_long   (too_long),
        .i_last       (last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver: random stalls, or a long hold-off when the stimulus asks for one.
    always @(posedge clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // Watchdog: too long without any word moving on any channel.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one input word, with an optional gap before it, until it is taken.
    task automatic send_word(input logic act, input logic start, input logic [7:0] data,
                             input logic [15:0] len, input bit counted);
        int gap;
        gap = 0;
        if ($urandom_range(99) < tx_idle_pct) begin
            gap = $urandom_range(1, 6);
        end
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        msg_start  <= start;
        data_byte  <= data;
        msg_length <= len;
        do @(posedge clk); while (in_stall);
        if (counted) begin
            useful_words++;
        end
    endtask

    // Sends the first count bytes of a message of len bytes.
    task automatic send_bytes(input int len, input int count);
        for (int k = 0; k < count; k++) begin
            send_word(1'b0, k == 0, 8'($urandom), (k == 0) ? 16'(len) : 16'($urandom), 1'b1);
        end
    endtask

    task automatic send_abort();
        send_word(1'b1, 1'b0, 8'($urandom), 16'($urandom), 1'b0);
    endtask

    task automatic write_mtu(input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        mtu_setting  = value;
    endtask

    // Holds the input back until every predicted word has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Packet capacity that the current MTU setting gives.
    function automatic int link_room();
        int mtu;
        mtu = mtu_setting;
        if (mtu < MIN_MTU) begin
            mtu = MIN_MTU;
        end
        if (mtu > MAX_MTU) begin
            mtu = MAX_MTU;
        end
        return mtu - ATT_OVERHEAD;
    endfunction

    // One random message: mostly well formed, some cut short, some noise.
    task automatic run_message();
        int room;
        int pick;
        int len;
        int short_max;
        room      = link_room();
        short_max = (room < 24) ? room : 24;
        pick      = $urandom_range(99);
        if (pick < 40) begin
            // Complete message that fits in one packet.
            len = $urandom_range(1, (room <= 60) ? room : 24);
            send_bytes(len, len);
        end else if (pick < 60 && room <= 60) begin
            // Complete framed message across a few chunks.
            len = $urandom_range(room + 1, room + 30);
            send_bytes(len, len);
        end else if (pick < 75) begin
            // Framed message cut short, then aborted or superseded by the next start.
            len = $urandom_range(room + 1, MAX_MESSAGE);
            send_bytes(len, $urandom_range(1, 40));
            if ($urandom_range(1) != 0) begin
                send_abort();
            end
        end else if (pick < 83) begin
            // Raw message cut short.
            len = $urandom_range(2, short_max);
            send_bytes(len, $urandom_range(1, len - 1));
            if ($urandom_range(1) != 0) begin
                send_abort();
            end
        end else if (pick < 88) begin
            // Over-long message: one error word, the bytes after it are dropped.
            send_word(1'b0, 1'b1, 8'($urandom),
                      16'($urandom_range(MAX_MESSAGE + 1, 65535)), 1'b1);
            repeat ($urandom_range(0, 2)) send_word(1'b0, 1'b0, 8'($urandom),
                                                    16'($urandom), 1'b0);
        end else if (pick < 93) begin
            // Zero-length start, then a stray byte.
            send_word(1'b0, 1'b1, 8'($urandom), 16'd0, 1'b0);
            send_word(1'b0, 1'b0, 8'($urandom), 16'($urandom), 1'b0);
        end else begin
            send_word(1'b1, 1'($urandom_range(1)), 8'($urandom), 16'($urandom), 1'b0);
        end
    endtask

    initial begin
        int step_base;
        logic [15:0] mtu_plan [MTU_STEPS];
        mtu_plan = '{16'd0, 16'd35, 16'd65535, 16'd24, 16'd22, 16'd517, 16'd40};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at the reset MTU of 23: capacity 20, chunks of 12.
        tx_idle_pct = 14;
        rx_idle_pct = 54;
        send_word(1'b0, 1'b0, 8'h5A, 16'hFFFF, 1'b0);    // stray byte while idle
        send_word(1'b0, 1'b1, 8'hA5, 16'h0000, 1'b0);    // zero length
        send_word(1'b0, 1'b1, 8'h00, 16'hFFFF, 1'b1);    // longest length, too long
        send_word(1'b0, 1'b0, 8'h11, 16'h0010, 1'b0);    // dropped
        send_word(1'b0, 1'b1, 8'hFF, 16'd8193, 1'b1);    // just over the limit
        send_word(1'b1, 1'b1, 8'h3C, 16'd5, 1'b0);       // abort wins over start
        send_word(1'b0, 1'b1, 8'hFF, 16'd1, 1'b1);       // one-byte raw packet
        send_word(1'b0, 1'b1, 8'h00, 16'd2, 1'b1);
        send_word(1'b0, 1'b0, 8'h80, 16'h0000, 1'b1);
        send_bytes(MAX_MESSAGE, 13);                      // largest message, two chunks
        send_bytes(4, 2);                                 // start in the middle of it
        send_abort();
        wait_drained();

        // Random part, one MTU setting after another; idling changes per phase.
        for (int s = 0; s < MTU_STEPS; s++) begin
            if (s < 2) begin
                tx_idle_pct = 14;
                rx_idle_pct = 54;
            end else if (s < 4) begin
                tx_idle_pct = 54;
                rx_idle_pct = 14;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_mtu((s == MTU_STEPS - 1) ? 16'($urandom_range(23, 64)) : mtu_plan[s]);
            if (s == 0) begin
                // Receiver holds off while a framed message keeps coming in.
                hold_seq <= hold_seq + 1;
                send_bytes(60, 60);
                wait_drained();
            end
            step_base = useful_words;
            while (useful_words - step_base < WORDS_PER_STEP) begin
                run_message();
            end
            wait_drained();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
